/* hw/rtl/gls_pkg.sv */
// ----------------------------------------------------------------------------
// gls_pkg: shared definitions for the grid line-of-sight block
// Map geometry, field widths, register indexes, sequencer states and the
// control structs passed between the top level and the line walker.
// ----------------------------------------------------------------------------
package gls_pkg;

    // Map storage geometry.
    localparam int MAX_DIM   = 256;
    localparam int COORD_W   = $clog2(MAX_DIM);
    localparam int ADDR_W    = 2 * COORD_W;
    localparam int MAP_DEPTH = MAX_DIM * MAX_DIM;

    // Configuration registers.
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;
    localparam logic [CFG_W-1:0]     GRID_DIM_RESET  = 9'd256;

    // Stream payload widths.
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 8;

    // Item kinds carried on tuser.
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // Bresenham error term: |err| stays below 2*MAX_DIM, doubled for e2.
    localparam int ERR_W = COORD_W + 3;
    localparam int E2_W  = ERR_W + 1;

    typedef logic [COORD_W-1:0] coord_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_RESULT
    } gls_state_t;

    // Control from the sequencer to the walker.
    typedef struct packed {
        logic   load;
        logic   advance;
        coord_t start_x;
        coord_t start_y;
        coord_t goal_x;
        coord_t goal_y;
    } walk_ctrl_t;

    // Status from the walker back to the sequencer.
    typedef struct packed {
        logic   at_goal;
        coord_t cur_x;
        coord_t cur_y;
    } walk_stat_t;

endpackage

/* hw/rtl/gls_map_ram.sv */
// ----------------------------------------------------------------------------
// gls_map_ram: one-bit occupancy map
// Single write port and single registered read port; contents are not
// cleared and read as unknown until written.
// ----------------------------------------------------------------------------
module gls_map_ram (
    input  logic                      clk,
    input  logic                      we,
    input  logic [gls_pkg::ADDR_W-1:0] waddr,
    input  logic                      wdata,
    input  logic                      re,
    input  logic [gls_pkg::ADDR_W-1:0] raddr,
    output logic                      rdata
);
    import gls_pkg::*;

    logic mem [MAP_DEPTH];
    logic rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/gls_walker.sv */
// ----------------------------------------------------------------------------
// gls_walker: Bresenham line stepper
// Holds the current point and error term and advances one cell per
// request toward the goal point.
// ----------------------------------------------------------------------------
module gls_walker (
    input  logic                clk,
    input  logic                rst_n,
    input  gls_pkg::walk_ctrl_t ctrl,
    output gls_pkg::walk_stat_t stat
);
    import gls_pkg::*;

    coord_t                  x_reg, x_next;
    coord_t                  y_reg, y_next;
    coord_t                  gx_reg, gx_next;
    coord_t                  gy_reg, gy_next;
    coord_t                  dx_reg, dx_next;
    coord_t                  dy_reg, dy_next;
    logic                    sx_neg_reg, sx_neg_next;
    logic                    sy_neg_reg, sy_neg_next;
    logic signed [ERR_W-1:0] err_reg, err_next;

    logic signed [E2_W-1:0]  e2;
    logic signed [E2_W-1:0]  dx_s;
    logic signed [E2_W-1:0]  dy_s;
    coord_t                  ld_dx;
    coord_t                  ld_dy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg      <= '0;
            y_reg      <= '0;
            gx_reg     <= '0;
            gy_reg     <= '0;
            dx_reg     <= '0;
            dy_reg     <= '0;
            sx_neg_reg <= 1'b0;
            sy_neg_reg <= 1'b0;
            err_reg    <= '0;
        end
        else
        begin
            x_reg      <= x_next;
            y_reg      <= y_next;
            gx_reg     <= gx_next;
            gy_reg     <= gy_next;
            dx_reg     <= dx_next;
            dy_reg     <= dy_next;
            sx_neg_reg <= sx_neg_next;
            sy_neg_reg <= sy_neg_next;
            err_reg    <= err_next;
        end
    end

    always_comb
    begin
        ld_dx = (ctrl.goal_x > ctrl.start_x) ? ctrl.goal_x - ctrl.start_x
                                             : ctrl.start_x - ctrl.goal_x;
        ld_dy = (ctrl.goal_y > ctrl.start_y) ? ctrl.goal_y - ctrl.start_y
                                             : ctrl.start_y - ctrl.goal_y;
        dx_s  = signed'({{(E2_W-COORD_W){1'b0}}, dx_reg});
        dy_s  = signed'({{(E2_W-COORD_W){1'b0}}, dy_reg});
        e2    = {err_reg, 1'b0};

        x_next      = x_reg;
        y_next      = y_reg;
        gx_next     = gx_reg;
        gy_next     = gy_reg;
        dx_next     = dx_reg;
        dy_next     = dy_reg;
        sx_neg_next = sx_neg_reg;
        sy_neg_next = sy_neg_reg;
        err_next    = err_reg;

        if (ctrl.load)
        begin
            x_next      = ctrl.start_x;
            y_next      = ctrl.start_y;
            gx_next     = ctrl.goal_x;
            gy_next     = ctrl.goal_y;
            dx_next     = ld_dx;
            dy_next     = ld_dy;
            sx_neg_next = !(ctrl.start_x < ctrl.goal_x);
            sy_neg_next = !(ctrl.start_y < ctrl.goal_y);
            err_next    = signed'({{(ERR_W-COORD_W){1'b0}}, ld_dx})
                        - signed'({{(ERR_W-COORD_W){1'b0}}, ld_dy});
        end
        else if (ctrl.advance)
        begin
            // Both moves use the doubled error from before the step.
            if (e2 > -dy_s)
            begin
                err_next = err_next - ERR_W'(dy_s);
                x_next   = sx_neg_reg ? x_reg - 1'b1 : x_reg + 1'b1;
            end
            if (e2 < dx_s)
            begin
                err_next = err_next + ERR_W'(dx_s);
                y_next   = sy_neg_reg ? y_reg - 1'b1 : y_reg + 1'b1;
            end
        end
    end

    assign stat.at_goal = (x_reg == gx_reg) && (y_reg == gy_reg);
    assign stat.cur_x   = x_reg;
    assign stat.cur_y   = y_reg;

endmodule

/* hw/rtl/grid_line_of_sight.sv */
// ----------------------------------------------------------------------------
// grid_line_of_sight: Bresenham line-of-sight checker over a one-bit map
// Top level: stream ports, configuration registers, the query sequencer and
// the output register.
// ----------------------------------------------------------------------------
// Usage. Input transactions arrive on the s_axis group. tuser carries the
// kind: a write transaction stores cell_free at (start_x, start_y) in the
// internal map and produces no output; a query transaction walks the
// Bresenham line from the start cell toward the goal cell and returns one
// output transaction on m_axis whose bit 0 is 1 when every cell before the
// goal is free and inside the configured grid, and 0 otherwise.
// A write is stored and the next transaction can follow immediately.
// A query holds s_axis_tready low while it walks: the shared stepper and the
// single read port of the map visit one cell per cycle. A clear answer lands
// in the output register once the walker has visited each cell before the
// goal, the sequencer has judged the last cell read and the answer has moved
// out of ST_RESULT. A blocked cell stops the walk early. s_axis_tready rises
// again as the answer enters the output register. A new transaction is
// accepted while the previous answer still waits in the output register; a
// second answer waits in the sequencer, with the input held off, until the
// receiver raises m_axis_tready. Reset clears the sequencer, empties the
// output register and sets both grid dimensions to 256. The map itself is
// not cleared: every cell must be written before a query visits it. The user
// must write grid_width and grid_height through cfg_we/cfg_index/cfg_wdata
// only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module grid_line_of_sight (
    input  logic                             clk,
    input  logic                             rst_n,
    // Input stream.
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // tdata: start_x[7:0], start_y[15:8], goal_x[23:16], goal_y[31:24],
    //        cell_free[32], zero padding [39:33]
    input  logic [gls_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // tuser: kind[0]
    input  logic                             s_axis_tuser,
    // Output stream.
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // tdata: clear[0], zero padding [7:1]
    output logic [gls_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // Configuration write port.
    input  logic                             cfg_we,
    input  logic [gls_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gls_pkg::CFG_W-1:0]        cfg_wdata
);
    import gls_pkg::*;

    gls_state_t        state_reg, state_next;
    logic [CFG_W-1:0]  grid_width_reg;
    logic [CFG_W-1:0]  grid_height_reg;
    logic              pend_reg, pend_next;
    logic              inrange_reg, inrange_next;
    logic              result_reg, result_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_clear_reg, out_clear_next;

    walk_ctrl_t        wctrl;
    walk_stat_t        wstat;
    logic              in_accept;
    logic              map_we;
    logic              map_re;
    logic              map_rdata;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr;
    logic              hit;
    logic              cur_inrange;

    coord_t            in_start_x;
    coord_t            in_start_y;
    coord_t            in_goal_x;
    coord_t            in_goal_y;
    logic              in_cell_free;

    assign in_start_x   = s_axis_tdata[COORD_W-1:0];
    assign in_start_y   = s_axis_tdata[2*COORD_W-1:COORD_W];
    assign in_goal_x    = s_axis_tdata[3*COORD_W-1:2*COORD_W];
    assign in_goal_y    = s_axis_tdata[4*COORD_W-1:3*COORD_W];
    assign in_cell_free = s_axis_tdata[4*COORD_W];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= GRID_DIM_RESET;
            grid_height_reg <= GRID_DIM_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_GRID_WIDTH:  grid_width_reg  <= cfg_wdata;
                REG_GRID_HEIGHT: grid_height_reg <= cfg_wdata;
                default:         ;
            endcase
        end
    end

    // Map writes go straight through from an accepted write transaction.
    assign map_we = in_accept && (s_axis_tuser == KIND_WRITE);
    assign waddr  = {in_start_y, in_start_x};
    assign raddr  = {wstat.cur_y, wstat.cur_x};

    gls_map_ram u_map (
        .clk   (clk),
        .we    (map_we),
        .waddr (waddr),
        .wdata (in_cell_free),
        .re    (map_re),
        .raddr (raddr),
        .rdata (map_rdata)
    );

    gls_walker u_walker (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (wctrl),
        .stat  (wstat)
    );

    // A cell outside the configured grid counts as blocked.
    assign cur_inrange = ({1'b0, wstat.cur_x} < grid_width_reg)
                      && ({1'b0, wstat.cur_y} < grid_height_reg);

    // The cell read in the previous cycle is judged now, while the walker
    // already reads the next one.
    assign hit = pend_reg && !(inrange_reg && map_rdata);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pend_reg      <= 1'b0;
            inrange_reg   <= 1'b0;
            result_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            out_clear_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            inrange_reg   <= inrange_next;
            result_reg    <= result_next;
            out_valid_reg <= out_valid_next;
            out_clear_reg <= out_clear_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        pend_next       = 1'b0;
        inrange_next    = inrange_reg;
        result_next     = result_reg;
        out_clear_next  = out_clear_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        map_re          = 1'b0;
        wctrl.load      = 1'b0;
        wctrl.advance   = 1'b0;
        wctrl.start_x   = in_start_x;
        wctrl.start_y   = in_start_y;
        wctrl.goal_x    = in_goal_x;
        wctrl.goal_y    = in_goal_y;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && (s_axis_tuser == KIND_QUERY))
                begin
                    wctrl.load = 1'b1;
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                priority if (hit)
                begin
                    result_next = 1'b0;
                    state_next  = ST_RESULT;
                end
                else if (wstat.at_goal)
                begin
                    // The goal cell itself is never tested.
                    result_next = 1'b1;
                    state_next  = ST_RESULT;
                end
                else
                begin
                    map_re        = 1'b1;
                    pend_next     = 1'b1;
                    inrange_next  = cur_inrange;
                    wctrl.advance = 1'b1;
                end
            end
            ST_RESULT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_clear_next = result_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W-1){1'b0}}, out_clear_reg};

endmodule

/* hw/rtl/gls_checker.sv */
// ----------------------------------------------------------------------------
// gls_checker: port-level assertions for the line-of-sight block
// Watches the stream ports of grid_line_of_sight and is bound to it.
// ----------------------------------------------------------------------------
module gls_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           s_axis_tuser,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [gls_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import gls_pkg::*;

    // A stalled result stays offered with the same answer.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed or vanished while stalled");

    // A query occupies the sequencer: no new transaction in the next cycle.
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == KIND_QUERY)
        |=> !s_axis_tready)
        else $error("input accepted right after a query");

    // A map write does not stall the input: it stays ready after the write.
    a_write_fast: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == KIND_WRITE)
        |=> s_axis_tready)
        else $error("map write stalled the input");

    // Only the answer bit may be set in a result.
    a_out_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[OUT_DATA_W-1:1] == '0))
        else $error("padding bits set in result");

endmodule

bind grid_line_of_sight gls_checker u_gls_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
